[hw/rtl/sil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Field widths and operation codes shared by the sorted id list pair and its
// channel interfaces.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int OP_W  = 2;
    localparam int SEL_W = 1;
    localparam int VID_W = 16;
    localparam int POS_W = 4;
    localparam int RID_W = 16;
    localparam int CNT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

endpackage

[hw/rtl/sil_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_req_if
// Request channel: one list operation per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sil_req_if
    import sil_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [SEL_W-1:0] list_sel;
    logic [VID_W-1:0] vertex_id;
    logic [POS_W-1:0] position;

    modport source (
        output valid,
        input  ready,
        output op,
        output list_sel,
        output vertex_id,
        output position
    );

    modport sink (
        input  valid,
        output ready,
        input  op,
        input  list_sel,
        input  vertex_id,
        input  position
    );

endinterface

[hw/rtl/sil_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_rsp_if
// Response channel: one result item per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sil_rsp_if
    import sil_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [RID_W-1:0] read_id;
    logic             hit;
    logic             full_res;
    logic [CNT_W-1:0] count;

    modport source (
        output valid,
        input  ready,
        output read_id,
        output hit,
        output full_res,
        output count
    );

    modport sink (
        input  valid,
        output ready,
        input  read_id,
        input  hit,
        input  full_res,
        input  count
    );

endinterface

[hw/rtl/sorted_id_list_pair.sv]
`timescale 1ns / 1ps
// insert and remove walk the list where needed, between a setup and a finish state:
// the single ram read port walks one list entry per cycle; read does one ram read
// (none on a miss), and unknown op codes go straight from setup to finish
// one item in work at a time; the next is taken the cycle after the result is loaded
// a finished result waits in the output register until it is taken
// reset (rst_n, async, active low) empties both lists; entries themselves are not cleared
// ----------------------------------------------------------------------------
// sorted_id_list_pair
// Two bounded ascending id lists (incoming and outgoing) sharing one RAM,
// with insert, remove and positional read run by a small sequencer.
// ----------------------------------------------------------------------------
module sorted_id_list_pair
    import sil_pkg::*;
#(
    parameter int MAX_EDGES = 16,
    parameter int ID_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sil_req_if.sink   req,
    sil_rsp_if.source rsp
);

    localparam int AW        = $clog2(MAX_EDGES);
    localparam int CW        = $clog2(MAX_EDGES + 1);
    localparam int RAW       = AW + 1;
    localparam int RAM_DEPTH = 2 ** RAW;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_START    = 3'd1;
    localparam logic [2:0] ST_INS      = 3'd2;
    localparam logic [2:0] ST_INS_LAST = 3'd3;
    localparam logic [2:0] ST_REM      = 3'd4;
    localparam logic [2:0] ST_RDW      = 3'd5;
    localparam logic [2:0] ST_FIN      = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg;
    logic               sel_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               found_reg, found_next;
    logic               hit_reg, hit_next;
    logic               full_reg, full_next;
    logic [ID_BITS-1:0] rid_reg, rid_next;
    logic [CW-1:0]      in_cnt_reg, out_cnt_reg;

    logic               out_valid_reg;
    logic [RID_W-1:0]   out_read_id_reg;
    logic               out_hit_reg;
    logic               out_full_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               accept;
    logic [CW-1:0]      cnt_cur;
    logic               cnt_inc;
    logic               cnt_dec;
    logic               out_load;
    logic               read_ok;
    logic               rem_match;
    logic               rem_last;

    logic               ram_we;
    logic [AW-1:0]      w_idx;
    logic [AW-1:0]      r_idx;
    logic [ID_BITS-1:0] ram_wdata;
    logic [ID_BITS-1:0] ram_rdata;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign cnt_cur   = sel_reg ? out_cnt_reg : in_cnt_reg;
    assign read_ok   = 32'(pos_reg) < 32'(cnt_cur);
    assign rem_match = !found_reg && (ram_rdata == id_reg);
    assign rem_last  = (CW'(idx_reg) == (cnt_cur - CW'(1)));

    // both lists share one ram, the list select is the top address bit
    sil_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({sel_reg, w_idx}),
        .wdata (ram_wdata),
        .raddr ({sel_reg, r_idx}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        rid_next   = rid_reg;
        ram_we     = 1'b0;
        w_idx      = '0;
        ram_wdata  = id_reg;
        r_idx      = idx_reg;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    rid_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (cnt_cur == CW'(MAX_EDGES))
                        begin
                            full_next  = 1'b1;
                            state_next = ST_FIN;
                        end
                        else if (cnt_cur == '0)
                        begin
                            ram_we     = 1'b1;
                            w_idx      = '0;
                            cnt_inc    = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            // walk down from the last entry
                            r_idx      = AW'(cnt_cur - CW'(1));
                            idx_next   = AW'(cnt_cur - CW'(1));
                            state_next = ST_INS;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (cnt_cur == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            r_idx      = '0;
                            idx_next   = '0;
                            state_next = ST_REM;
                        end
                    end
                    OP_READ:
                    begin
                        if (read_ok)
                        begin
                            r_idx      = AW'(pos_reg);
                            state_next = ST_RDW;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_INS:
            begin
                ram_we = 1'b1;
                w_idx  = idx_reg + AW'(1);
                if (ram_rdata >= id_reg)
                begin
                    // entry moves up one slot, keep walking down
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        r_idx    = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = id_reg;
                    cnt_inc    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_INS_LAST:
            begin
                ram_we     = 1'b1;
                w_idx      = '0;
                ram_wdata  = id_reg;
                cnt_inc    = 1'b1;
                state_next = ST_FIN;
            end
            ST_REM:
            begin
                // after the match every entry moves down one slot
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    w_idx     = idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (found_reg || rem_match)
                begin
                    found_next = 1'b1;
                end
                r_idx = idx_reg + AW'(1);
                if (rem_last)
                begin
                    hit_next   = found_reg || rem_match;
                    cnt_dec    = found_reg || rem_match;
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_RDW:
            begin
                rid_next   = ram_rdata;
                hit_next   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            full_reg      <= 1'b0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            hit_reg   <= hit_next;
            full_reg  <= full_next;
            if (cnt_inc)
            begin
                if (sel_reg)
                begin
                    out_cnt_reg <= out_cnt_reg + CW'(1);
                end
                else
                begin
                    in_cnt_reg <= in_cnt_reg + CW'(1);
                end
            end
            else if (cnt_dec)
            begin
                if (sel_reg)
                begin
                    out_cnt_reg <= out_cnt_reg - CW'(1);
                end
                else
                begin
                    in_cnt_reg <= in_cnt_reg - CW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rid_reg <= rid_next;
        if (accept)
        begin
            op_reg  <= req.op;
            sel_reg <= req.list_sel;
            id_reg  <= ID_BITS'(req.vertex_id);
            pos_reg <= req.position;
        end
        if (out_load)
        begin
            out_read_id_reg <= RID_W'(rid_reg);
            out_hit_reg     <= hit_reg;
            out_full_reg    <= full_reg;
            out_count_reg   <= CNT_W'(cnt_cur);
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.read_id  = out_read_id_reg;
    assign rsp.hit      = out_hit_reg;
    assign rsp.full_res = out_full_reg;
    assign rsp.count    = out_count_reg;

endmodule

[hw/rtl/sil_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
